// ===== rtl/dfc_pkg.sv =====
package dfc_pkg;

	// Fixed-point format of the linear value
	localparam int FRACTION_BITS = 16;

	// Field widths
	localparam int MANT_W      = 13;
	localparam int EXP_W       = 2;
	localparam int CODE_W      = 16;
	localparam int VALUE_IN_W  = 32;
	localparam int VALUE_OUT_W = 30;
	localparam int MAG_W       = VALUE_IN_W;

	// Decode numerator is mantissa << FRACTION_BITS plus half the scale
	localparam int NUM_W   = MANT_W + FRACTION_BITS + 1;
	localparam int RECIP_W = NUM_W + 1;
	localparam int PROD_W  = NUM_W + RECIP_W;

	localparam logic [CODE_W-1:0] INVALID_WORD = 16'hFFFF;
	localparam logic [MANT_W-1:0] MANT_LIMIT   = 13'h1FFF;

	localparam logic [VALUE_OUT_W-2:0] VALUE_MAX_MAG = '1;

	// Encode limit and the per-scale thresholds: mag * d < LIMIT <=> mag < ceil(LIMIT / d)
	localparam logic [63:0] LIMIT     = 64'(MANT_LIMIT) << FRACTION_BITS;
	localparam logic [63:0] THR_10    = (LIMIT + 64'd9) / 64'd10;
	localparam logic [63:0] THR_100   = (LIMIT + 64'd99) / 64'd100;
	localparam logic [63:0] THR_1000  = (LIMIT + 64'd999) / 64'd1000;

	// Exact reciprocals for numerators below 2^NUM_W
	localparam int SHIFT_10   = NUM_W + 4;
	localparam int SHIFT_100  = NUM_W + 7;
	localparam int SHIFT_1000 = NUM_W + 10;

	localparam logic [63:0] RECIP_10   = ((64'd1 << SHIFT_10) + 64'd9) / 64'd10;
	localparam logic [63:0] RECIP_100  = ((64'd1 << SHIFT_100) + 64'd99) / 64'd100;
	localparam logic [63:0] RECIP_1000 = ((64'd1 << SHIFT_1000) + 64'd999) / 64'd1000;

	typedef enum logic {
		CMD_ENCODE = 1'b0,
		CMD_DECODE = 1'b1
	} cmd_t;

	typedef enum logic [EXP_W-1:0] {
		EXP_1    = 2'd0,
		EXP_10   = 2'd1,
		EXP_100  = 2'd2,
		EXP_1000 = 2'd3
	} exp_t;

	// Per-item control carried alongside the product
	typedef struct packed {
		logic decode;
		logic neg;
		exp_t exp;
		logic oor;
		logic nan;
	} ctl_t;

	function automatic logic [9:0] scale_of(input exp_t e);
		logic [9:0] s;
		unique case (e)
			EXP_1:    s = 10'd1;
			EXP_10:   s = 10'd10;
			EXP_100:  s = 10'd100;
			EXP_1000: s = 10'd1000;
			default:  s = 10'd1;
		endcase
		return s;
	endfunction

	function automatic logic [9:0] half_of(input exp_t e);
		logic [9:0] h;
		unique case (e)
			EXP_1:    h = 10'd0;
			EXP_10:   h = 10'd5;
			EXP_100:  h = 10'd50;
			EXP_1000: h = 10'd500;
			default:  h = 10'd0;
		endcase
		return h;
	endfunction

	function automatic logic [RECIP_W-1:0] recip_of(input exp_t e);
		logic [RECIP_W-1:0] r;
		unique case (e)
			EXP_1:    r = RECIP_W'(1);
			EXP_10:   r = RECIP_W'(RECIP_10);
			EXP_100:  r = RECIP_W'(RECIP_100);
			EXP_1000: r = RECIP_W'(RECIP_1000);
			default:  r = RECIP_W'(1);
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/dfc_front.sv =====
module dfc_front (
	input  logic                                    command,
	input  logic signed [dfc_pkg::VALUE_IN_W-1:0]   value_in,
	input  logic        [dfc_pkg::CODE_W-1:0]       code_in,
	output dfc_pkg::ctl_t                           ctl,
	output logic        [dfc_pkg::PROD_W-1:0]       prod
);
	import dfc_pkg::*;

	logic               neg_enc;
	logic [MAG_W-1:0]   mag;
	logic               oor;
	exp_t               exp_enc;
	exp_t               exp_dec;
	logic [MANT_W-1:0]  mant_dec;
	logic [NUM_W-1:0]   num;
	logic [NUM_W-1:0]   op_a;
	logic [RECIP_W-1:0] op_b;

	always_comb begin
		// encode side: magnitude, range check, largest scale that fits
		neg_enc = value_in[VALUE_IN_W-1];
		mag     = neg_enc ? MAG_W'(-value_in) : MAG_W'(value_in);
		oor     = 64'(mag) >= LIMIT;
		priority if (64'(mag) < THR_1000) begin
			exp_enc = EXP_1000;
		end else if (64'(mag) < THR_100) begin
			exp_enc = EXP_100;
		end else if (64'(mag) < THR_10) begin
			exp_enc = EXP_10;
		end else begin
			exp_enc = EXP_1;
		end

		// decode side: rounded numerator, divided later through the reciprocal
		exp_dec  = exp_t'(code_in[EXP_W-1:0]);
		mant_dec = code_in[MANT_W+EXP_W-1:EXP_W];
		num      = (NUM_W'(mant_dec) << FRACTION_BITS) + NUM_W'(half_of(exp_dec));

		ctl.decode = (command == CMD_DECODE);
		if (command == CMD_DECODE) begin
			op_a    = num;
			op_b    = recip_of(exp_dec);
			ctl.neg = code_in[CODE_W-1];
			ctl.exp = exp_dec;
			ctl.oor = 1'b0;
			ctl.nan = (code_in == INVALID_WORD);
		end else begin
			op_a    = oor ? '0 : NUM_W'(mag);
			op_b    = RECIP_W'(scale_of(exp_enc));
			ctl.neg = neg_enc;
			ctl.exp = exp_enc;
			ctl.oor = oor;
			ctl.nan = 1'b0;
		end

		// one shared multiplier for both directions
		prod = PROD_W'(op_a) * PROD_W'(op_b);
	end

endmodule

// ===== rtl/dfc_back.sv =====
module dfc_back (
	input  dfc_pkg::ctl_t                            ctl,
	input  logic        [dfc_pkg::PROD_W-1:0]        prod,
	output logic        [dfc_pkg::CODE_W-1:0]        code,
	output logic signed [dfc_pkg::VALUE_OUT_W-1:0]   value,
	output logic                                     oor,
	output logic                                     nan
);
	import dfc_pkg::*;

	logic [MANT_W-1:0]        mant_enc;
	logic [NUM_W-1:0]         quot;
	logic [VALUE_OUT_W-2:0]   mag_dec;
	logic [VALUE_OUT_W-1:0]   mag_ext;

	always_comb begin
		mant_enc = prod[FRACTION_BITS +: MANT_W];

		unique case (ctl.exp)
			EXP_1:    quot = NUM_W'(prod);
			EXP_10:   quot = NUM_W'(prod >> SHIFT_10);
			EXP_100:  quot = NUM_W'(prod >> SHIFT_100);
			EXP_1000: quot = NUM_W'(prod >> SHIFT_1000);
			default:  quot = NUM_W'(prod);
		endcase

		// saturate the decoded magnitude to the signed output range
		mag_dec = (64'(quot) > 64'(VALUE_MAX_MAG)) ? VALUE_MAX_MAG : (VALUE_OUT_W-1)'(quot);
		mag_ext = {1'b0, mag_dec};

		if (ctl.decode) begin
			code = '0;
			oor  = 1'b0;
			nan  = ctl.nan;
			if (ctl.nan) begin
				value = '0;
			end else begin
				value = ctl.neg ? VALUE_OUT_W'(-mag_ext) : mag_ext;
			end
		end else begin
			value = '0;
			nan   = 1'b0;
			oor   = ctl.oor;
			code  = ctl.oor ? INVALID_WORD : {ctl.neg, mant_enc, ctl.exp};
		end
	end

endmodule

// ===== rtl/decimal_float16_codec.sv =====
// Decimal 16-bit float codec.
//
// Input channel (in_valid / in_ready) carries one beat per conversion:
// command selects encode of value_in (signed, FRACTION_BITS fraction bits)
// or decode of code_in (sign, 13-bit mantissa, decimal exponent).
// Output channel (out_valid / out_ready) returns exactly one beat per input
// beat, in order: code_out and out_of_range for encode, value_out and
// not_a_number for decode; the unused fields of a beat are zero.
//
// Three registers: input register, product register after the one shared
// multiplier (scale for encode, reciprocal for decode), result register.
// Throughput is one beat per cycle while the receiver keeps out_ready high;
// the multiplier stage is the only deep path.
//
// Reset clears all valid flags; with every stage empty, in_ready is high
// during reset and after it. When the receiver stalls,
// the result register holds its beat and the stages behind it keep filling;
// in_ready drops once all three stages hold a beat.
module decimal_float16_codec (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    command,
	input  logic signed [dfc_pkg::VALUE_IN_W-1:0]   value_in,
	input  logic        [dfc_pkg::CODE_W-1:0]       code_in,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic        [dfc_pkg::CODE_W-1:0]       code_out,
	output logic signed [dfc_pkg::VALUE_OUT_W-1:0]  value_out,
	output logic                                    out_of_range,
	output logic                                    not_a_number
);
	import dfc_pkg::*;

	// stage 1: captured input beat
	logic                          v_s1;
	logic                          cmd_s1;
	logic signed [VALUE_IN_W-1:0]  value_s1;
	logic        [CODE_W-1:0]      code_s1;

	// stage 2: product and control
	logic                          v_s2;
	ctl_t                          ctl_s2;
	logic        [PROD_W-1:0]      prod_s2;

	// result register
	logic                          out_valid_q;
	logic        [CODE_W-1:0]      code_q;
	logic signed [VALUE_OUT_W-1:0] value_q;
	logic                          oor_q;
	logic                          nan_q;

	// combinational results
	ctl_t                          ctl_c;
	logic        [PROD_W-1:0]      prod_c;
	logic        [CODE_W-1:0]      code_c;
	logic signed [VALUE_OUT_W-1:0] value_c;
	logic                          oor_c;
	logic                          nan_c;

	logic adv_out;
	logic rdy_s2;
	logic rdy_s1;

	// a stage advances when it is empty or the stage ahead takes its beat
	assign adv_out  = !out_valid_q || out_ready;
	assign rdy_s2   = !v_s2 || adv_out;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	dfc_front u_front (
		.command  (cmd_s1),
		.value_in (value_s1),
		.code_in  (code_s1),
		.ctl      (ctl_c),
		.prod     (prod_c)
	);

	dfc_back u_back (
		.ctl   (ctl_s2),
		.prod  (prod_s2),
		.code  (code_c),
		.value (value_c),
		.oor   (oor_c),
		.nan   (nan_c)
	);

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	// payload: load only on a moving beat, hold otherwise
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			cmd_s1   <= command;
			value_s1 <= value_in;
			code_s1  <= code_in;
		end
		if (v_s1 && rdy_s2) begin
			ctl_s2  <= ctl_c;
			prod_s2 <= prod_c;
		end
		if (v_s2 && adv_out) begin
			code_q  <= code_c;
			value_q <= value_c;
			oor_q   <= oor_c;
			nan_q   <= nan_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign code_out     = code_q;
	assign value_out    = value_q;
	assign out_of_range = oor_q;
	assign not_a_number = nan_q;

	// an encode flag and a decode flag never appear on the same beat
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(oor_q && nan_q))
		else $error("out_of_range and not_a_number both set");

	// out of range forces the invalid marker and a zero value
	a_oor_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && oor_q |-> (code_q == INVALID_WORD) && (value_q == '0))
		else $error("out-of-range beat without invalid marker");

	// not-a-number decodes to zero with no code
	a_nan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && nan_q |-> (value_q == '0) && (code_q == '0))
		else $error("not-a-number beat with nonzero fields");

	// a stalled product stage holds its beat
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy_s2 |=> v_s2 && $stable(prod_s2) && $stable(ctl_s2))
		else $error("product stage lost a stalled beat");

	// an accepted beat lands in the input register
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted beat not captured");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import dfc_pkg::*;

	// Watchdog: cycles in a row with no beat on either channel
	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_BEATS = 1300;
	// Run the last beats with both sides streaming
	localparam int STEADY_TAIL  = 200;
	localparam int REPORT_MAX   = 10;

	// Encode range limit and the lowest magnitude of each exponent band:
	// mag * d < limit holds exactly for mag below ceil(limit / d)
	localparam logic [63:0] ENC_LIMIT = 64'(MANT_LIMIT) << FRACTION_BITS;
	localparam logic [63:0] BAND_10   = (ENC_LIMIT + 64'd9) / 64'd10;
	localparam logic [63:0] BAND_100  = (ENC_LIMIT + 64'd99) / 64'd100;
	localparam logic [63:0] BAND_1000 = (ENC_LIMIT + 64'd999) / 64'd1000;

	typedef struct packed {
		logic [CODE_W-1:0]      code;
		logic [VALUE_OUT_W-1:0] value;
		logic                   oor;
		logic                   nan;
	} conversion_t;

	// Predict each conversion and match result beats in order
	class codec_scoreboard;
		conversion_t pending_conversions[$];
		int failures;

		function logic [63:0] decade_scale(exp_t e);
			case (e)
				EXP_10:   return 64'd10;
				EXP_100:  return 64'd100;
				EXP_1000: return 64'd1000;
				default:  return 64'd1;
			endcase
		endfunction

		function conversion_t convert(cmd_t cmd, logic [VALUE_IN_W-1:0] v, logic [CODE_W-1:0] w);
			conversion_t r;
			logic [63:0] mag;
			logic [63:0] scale;
			logic [MANT_W-1:0] mant;
			logic [VALUE_IN_W-1:0] absv;
			logic neg;
			exp_t e;
			r = '0;
			if (cmd == CMD_ENCODE) begin
				neg = v[VALUE_IN_W-1];
				// take the magnitude at 32 bits so the most negative input gives 2^31
				absv = neg ? (~v + 32'd1) : v;
				mag = 64'(absv);
				if (mag >= ENC_LIMIT) begin
					r.code = INVALID_WORD;
					r.oor = 1'b1;
				end else begin
					if (mag * 64'd1000 < ENC_LIMIT)
						e = EXP_1000;
					else if (mag * 64'd100 < ENC_LIMIT)
						e = EXP_100;
					else if (mag * 64'd10 < ENC_LIMIT)
						e = EXP_10;
					else
						e = EXP_1;
					mant = MANT_W'((mag * decade_scale(e)) >> FRACTION_BITS);
					r.code = {neg, mant, e};
				end
			end else if (w == INVALID_WORD) begin
				r.nan = 1'b1;
			end else begin
				e = exp_t'(w[EXP_W-1:0]);
				scale = decade_scale(e);
				mag = ((64'(w[14:2]) << FRACTION_BITS) + scale / 64'd2) / scale;
				if (mag > 64'(VALUE_MAX_MAG))
					mag = 64'(VALUE_MAX_MAG);
				r.value = w[15] ? VALUE_OUT_W'(~mag + 64'd1) : VALUE_OUT_W'(mag);
			end
			return r;
		endfunction

		function void note_input(cmd_t cmd, logic [VALUE_IN_W-1:0] v, logic [CODE_W-1:0] w);
			pending_conversions.push_back(convert(cmd, v, w));
		endfunction

		function void check_result(logic [CODE_W-1:0] code, logic [VALUE_OUT_W-1:0] value,
				logic oor, logic nan);
			conversion_t got;
			conversion_t want;
			got = '{code, value, oor, nan};
			if (pending_conversions.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("%0t: result beat with nothing pending: code %h value %h oor %b nan %b",
						$time, code, value, oor, nan);
				return;
			end
			want = pending_conversions.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("%0t: mismatch: code %h/%h value %h/%h oor %b/%b nan %b/%b (exp/got)",
						$time, want.code, got.code, want.value, got.value,
						want.oor, got.oor, want.nan, got.nan);
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic                          command;
	logic signed [VALUE_IN_W-1:0]  value_in;
	logic        [CODE_W-1:0]      code_in;
	logic                          out_valid;
	logic                          out_ready;
	logic        [CODE_W-1:0]      code_out;
	logic signed [VALUE_OUT_W-1:0] value_out;
	logic                          out_of_range;
	logic                          not_a_number;

	// High for the tail of the run: no idling on either side
	logic steady = 1'b0;

	codec_scoreboard sb = new();

	decimal_float16_codec DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.value_in     (value_in),
		.code_in      (code_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.code_out     (code_out),
		.value_out    (value_out),
		.out_of_range (out_of_range),
		.not_a_number (not_a_number)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drive one beat from a falling edge; hold it until the block takes it,
	// then return on the next falling edge. Insert an idle burst ahead of it
	// now and then.
	task automatic send_beat(cmd_t cmd, logic [VALUE_IN_W-1:0] v, logic [CODE_W-1:0] w);
		int gap;
		if (!steady && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			gap = $urandom_range(1, 7);
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		command  = cmd;
		value_in = v;
		code_in  = w;
		do @(posedge clk); while (!in_ready);
		sb.note_input(cmd, v, w);
		@(negedge clk);
	endtask

	// Pick a random beat: mostly in-range encodes spread over the four
	// exponent bands and random decodes, plus raw 32-bit encodes (mostly
	// out of range) and the invalid marker / negative zero words.
	task automatic random_beat();
		int sel;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [VALUE_IN_W-1:0] mag;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			case ($urandom_range(0, 3))
				0: begin lo = 64'd0;    hi = BAND_1000 - 1; end
				1: begin lo = BAND_1000; hi = BAND_100 - 1; end
				2: begin lo = BAND_100;  hi = BAND_10 - 1; end
				default: begin lo = BAND_10; hi = ENC_LIMIT - 1; end
			endcase
			mag = $urandom_range(32'(hi), 32'(lo));
			send_beat(CMD_ENCODE, $urandom_range(0, 1) ? -mag : mag, $urandom);
		end else if (sel < 55) begin
			send_beat(CMD_ENCODE, $urandom, $urandom);
		end else if (sel < 95) begin
			send_beat(CMD_DECODE, $urandom, $urandom_range(0, 65535));
		end else if (sel < 98) begin
			send_beat(CMD_DECODE, $urandom, INVALID_WORD);
		end else begin
			send_beat(CMD_DECODE, $urandom, {1'b1, 13'd0, 2'($urandom_range(0, 3))});
		end
	endtask

	// Receiver: alternate ready runs with stall bursts, steady at the end
	initial begin
		int n;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!steady && $urandom_range(0, 2) == 0) begin
				out_ready = 1'b0;
				n = $urandom_range(1, 7);
			end else begin
				out_ready = 1'b1;
				n = $urandom_range(1, 16);
			end
			repeat (n) @(negedge clk);
		end
	end

	// Check every result beat taken at a rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(code_out, value_out, out_of_range, not_a_number);
	end

	// Watchdog: end the run when neither channel moves for too long
	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("[decimal_float16_codec] ERROR");
		$finish;
	end

	initial begin
		logic [VALUE_IN_W-1:0] boundary_values[15];
		logic [CODE_W-1:0] boundary_words[10];
		// Encode corners: zero, tiny values of both signs (tiny negative keeps
		// the sign with a zero mantissa), the full 32-bit extremes, both sides
		// of the range limit in both signs, and both sides of each band edge.
		boundary_values = '{
			32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'(ENC_LIMIT - 1), 32'(ENC_LIMIT), 32'(64'd1 - ENC_LIMIT), 32'(-ENC_LIMIT),
			32'(BAND_1000 - 1), 32'(BAND_1000), 32'(BAND_100 - 1), 32'(BAND_100),
			32'(BAND_10 - 1), 32'(BAND_10)
		};
		// Decode corners: zero, negative zero, invalid marker, largest
		// mantissa at each end of the exponent, largest negative words next to
		// the marker, sign with zero mantissa, smallest mantissa at scales 10/1000
		boundary_words = '{
			16'h0000, 16'h8000, INVALID_WORD, 16'h7FFF, 16'h7FFC,
			16'hFFFE, 16'hFFFC, 16'h8003, 16'h0005, 16'h0007
		};

		arst_n   = 1'b0;
		in_valid = 1'b0;
		command  = CMD_ENCODE;
		value_in = '0;
		code_in  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (boundary_values[i])
			send_beat(CMD_ENCODE, boundary_values[i], $urandom);
		foreach (boundary_words[i])
			send_beat(CMD_DECODE, $urandom, boundary_words[i]);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i == RANDOM_BEATS - STEADY_TAIL)
				steady = 1'b1;
			random_beat();
		end
		in_valid = 1'b0;

		// Drain, then keep clocking to catch any stray beat
		while (sb.pending_conversions.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.failures == 0 && sb.pending_conversions.size() == 0)
			$display("[decimal_float16_codec] OK");
		else
			$display("[decimal_float16_codec] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/dfc_pkg.sv
rtl/dfc_front.sv
rtl/dfc_back.sv
rtl/decimal_float16_codec.sv
bench/tb.sv
